// ===== rtl/midpoint_triangle_subdivider_macros.svh =====
// Assertion helpers for the subdivider; clk and rst_n come from the using scope.
`ifndef MIDPOINT_TRIANGLE_SUBDIVIDER_MACROS_SVH
`define MIDPOINT_TRIANGLE_SUBDIVIDER_MACROS_SVH

`define MTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mts_pkg.sv =====
`default_nettype none
package mts_pkg;
  localparam int COORD_W     = 16;
  localparam int FRAC_W      = COORD_W - 2;
  localparam int MAX_DEPTH   = 3;
  localparam int LVL_W       = 2;
  localparam int STACK_DEPTH = 3 * MAX_DEPTH;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int NUM_W       = COORD_W + FRAC_W;
  localparam int Q_W         = FRAC_W + 1;
  localparam int CNT_W       = $clog2(COORD_W);

  localparam logic [CFG_IDX_W-1:0] REG_DEPTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NORM  = CFG_IDX_W'(1);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  typedef struct packed {
    vtx_t a;
    vtx_t b;
    vtx_t c;
  } tri_t;

  typedef struct packed {
    tri_t             t;
    logic [LVL_W-1:0] lvl;
  } frame_t;

  typedef struct packed {
    logic start;
    vtx_t v;
  } norm_req_t;

  typedef struct packed {
    logic done;
    vtx_t v;
  } norm_rsp_t;

  function automatic coord_t half_of(coord_t p, coord_t q);
    logic signed [COORD_W:0] s;
    s = {p[COORD_W-1], p} + {q[COORD_W-1], q};
    return s[COORD_W:1];
  endfunction

  function automatic vtx_t half_sum(vtx_t p, vtx_t q);
    vtx_t m;
    m.x = half_of(p.x, q.x);
    m.y = half_of(p.y, q.y);
    m.z = half_of(p.z, q.z);
    return m;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/mts_if.sv =====
`default_nettype none
interface mts_in_if import mts_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t in_a_x;
  coord_t in_a_y;
  coord_t in_a_z;
  coord_t in_b_x;
  coord_t in_b_y;
  coord_t in_b_z;
  coord_t in_c_x;
  coord_t in_c_y;
  coord_t in_c_z;
  modport source (output valid, in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z,
                  in_c_x, in_c_y, in_c_z, input ready);
  modport sink (input valid, in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z,
                in_c_x, in_c_y, in_c_z, output ready);
endinterface

interface mts_out_if import mts_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_a_x;
  coord_t out_a_y;
  coord_t out_a_z;
  coord_t out_b_x;
  coord_t out_b_y;
  coord_t out_b_z;
  coord_t out_c_x;
  coord_t out_c_y;
  coord_t out_c_z;
  logic   last_triangle;
  modport source (output valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
                  out_c_x, out_c_y, out_c_z, last_triangle, input ready);
  modport sink (input valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
                out_c_x, out_c_y, out_c_z, last_triangle, output ready);
endinterface

interface mts_cfg_if import mts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/mts_norm.sv =====
`default_nettype none
module mts_norm import mts_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  norm_req_t req,
  output norm_rsp_t rsp
);
  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SQ    = 3'd1;
  localparam logic [2:0] N_SQRT  = 3'd2;
  localparam logic [2:0] N_DLOAD = 3'd3;
  localparam logic [2:0] N_DIV   = 3'd4;
  localparam logic [2:0] N_DONE  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  vtx_t               vin_r;
  logic [COORD_W-1:0] mag_r [3];
  logic               neg_r [3];
  coord_t             res_r [3];
  logic [SQ_W-1:0]    acc_r;
  logic [COORD_W+1:0] rem_r;
  logic [COORD_W-1:0] root_r;
  logic [COORD_W-1:0] drem_r;
  logic [Q_W-1:0]     dq_r;

  logic [SQ_W-1:0]    prod;
  logic [COORD_W+3:0] rem_t, trial;
  logic               sq_ge;
  logic [NUM_W-1:0]   num;
  logic [COORD_W:0]   dt;
  logic               d_ge;
  logic [Q_W-1:0]     dq_nxt;
  coord_t             q_signed;

  assign prod     = SQ_W'(mag_r[idx_r]) * SQ_W'(mag_r[idx_r]);
  assign rem_t    = {rem_r, acc_r[SQ_W-1 -: 2]};
  assign trial    = {2'b00, root_r, 2'b01};
  assign sq_ge    = rem_t >= trial;
  assign num      = {mag_r[idx_r], FRAC_W'(0)} + NUM_W'(root_r >> 1);
  assign dt       = {drem_r, dq_r[Q_W-1]};
  assign d_ge     = dt >= {1'b0, root_r};
  assign dq_nxt   = {dq_r[Q_W-2:0], d_ge};
  assign q_signed = neg_r[idx_r] ? -COORD_W'(dq_nxt) : COORD_W'(dq_nxt);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      N_IDLE: begin
        if (req.start) begin
          state_nxt = N_SQ;
          idx_nxt   = 2'd0;
        end
      end
      N_SQ: begin
        if (idx_r == 2'd2) begin
          state_nxt = N_SQRT;
          cnt_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      N_SQRT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(COORD_W - 1)) begin
          idx_nxt   = 2'd0;
          state_nxt = ({root_r[COORD_W-2:0], sq_ge} == '0) ? N_DONE : N_DLOAD;
        end
      end
      N_DLOAD: begin
        state_nxt = N_DIV;
        cnt_nxt   = '0;
      end
      N_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          if (idx_r == 2'd2) begin
            state_nxt = N_DONE;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = N_DLOAD;
          end
        end
      end
      N_DONE:  state_nxt = N_IDLE;
      default: state_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      idx_r   <= 2'd0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      N_IDLE: begin
        if (req.start) begin
          vin_r    <= req.v;
          mag_r[0] <= req.v.x[COORD_W-1] ? COORD_W'(-req.v.x) : COORD_W'(req.v.x);
          mag_r[1] <= req.v.y[COORD_W-1] ? COORD_W'(-req.v.y) : COORD_W'(req.v.y);
          mag_r[2] <= req.v.z[COORD_W-1] ? COORD_W'(-req.v.z) : COORD_W'(req.v.z);
          neg_r[0] <= req.v.x[COORD_W-1];
          neg_r[1] <= req.v.y[COORD_W-1];
          neg_r[2] <= req.v.z[COORD_W-1];
          acc_r    <= '0;
          rem_r    <= '0;
          root_r   <= '0;
        end
      end
      N_SQ: acc_r <= acc_r + prod;
      N_SQRT: begin
        acc_r  <= {acc_r[SQ_W-3:0], 2'b00};
        rem_r  <= sq_ge ? (COORD_W+2)'(rem_t - trial) : (COORD_W+2)'(rem_t);
        root_r <= {root_r[COORD_W-2:0], sq_ge};
        res_r[0] <= vin_r.x;
        res_r[1] <= vin_r.y;
        res_r[2] <= vin_r.z;
      end
      N_DLOAD: begin
        drem_r <= COORD_W'(num[NUM_W-1:Q_W]);
        dq_r   <= num[Q_W-1:0];
      end
      N_DIV: begin
        drem_r <= d_ge ? COORD_W'(dt - {1'b0, root_r}) : dt[COORD_W-1:0];
        dq_r   <= dq_nxt;
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          res_r[idx_r] <= q_signed;
        end
      end
      N_DONE: ;
      default: ;
    endcase
  end

  assign rsp.done = state_r == N_DONE;
  assign rsp.v    = '{x: res_r[0], y: res_r[1], z: res_r[2]};
endmodule
`default_nettype wire

// ===== rtl/mts_ctrl.sv =====
`default_nettype none
module mts_ctrl import mts_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [LVL_W-1:0] depth,
  input  wire logic       norm_en,
  mts_in_if.sink          in_ch,
  mts_out_if.source       out_ch,
  output norm_req_t       req,
  input  norm_rsp_t       rsp
);
  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_NODE  = 3'd1;
  localparam logic [2:0] C_MID   = 3'd2;
  localparam logic [2:0] C_NWAIT = 3'd3;
  localparam logic [2:0] C_PUSH  = 3'd4;
  localparam logic [2:0] C_EMIT  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [SP_W-1:0]  sp_r, sp_nxt;
  logic [1:0]       mi_r, mi_nxt;
  logic [1:0]       pc_r, pc_nxt;
  tri_t             cur_r;
  logic [LVL_W-1:0] lvl_r;
  vtx_t             mid_r [3];
  frame_t           stack_r [STACK_DEPTH];

  vtx_t             mid_raw;
  frame_t           push_frame;
  logic [IDX_W-1:0] pop_idx;
  logic             mid_take;
  vtx_t             mid_val;
  tri_t             in_tri;

  assign in_tri = '{a: '{x: in_ch.in_a_x, y: in_ch.in_a_y, z: in_ch.in_a_z},
                    b: '{x: in_ch.in_b_x, y: in_ch.in_b_y, z: in_ch.in_b_z},
                    c: '{x: in_ch.in_c_x, y: in_ch.in_c_y, z: in_ch.in_c_z}};
  assign pop_idx = IDX_W'(sp_r - 1'b1);

  always_comb begin
    unique case (mi_r)
      2'd0:    mid_raw = half_sum(cur_r.a, cur_r.b);
      2'd1:    mid_raw = half_sum(cur_r.b, cur_r.c);
      default: mid_raw = half_sum(cur_r.c, cur_r.a);
    endcase
  end

  always_comb begin
    push_frame.lvl = lvl_r - 1'b1;
    unique case (pc_r)
      2'd0:    push_frame.t = '{a: mid_r[0], b: mid_r[1], c: mid_r[2]};
      2'd1:    push_frame.t = '{a: mid_r[2], b: mid_r[1], c: cur_r.c};
      default: push_frame.t = '{a: mid_r[0], b: cur_r.b, c: mid_r[1]};
    endcase
  end

  assign req.start = (state_r == C_MID) && norm_en;
  assign req.v     = mid_raw;
  assign mid_take  = ((state_r == C_MID) && !norm_en) || ((state_r == C_NWAIT) && rsp.done);
  assign mid_val   = (state_r == C_NWAIT) ? rsp.v : mid_raw;

  always_comb begin
    state_nxt = state_r;
    sp_nxt    = sp_r;
    mi_nxt    = mi_r;
    pc_nxt    = pc_r;
    unique case (state_r)
      C_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = C_NODE;
          sp_nxt    = '0;
        end
      end
      C_NODE: begin
        mi_nxt    = 2'd0;
        state_nxt = (lvl_r == '0) ? C_EMIT : C_MID;
      end
      C_MID, C_NWAIT: begin
        if (state_r == C_MID && norm_en) begin
          state_nxt = C_NWAIT;
        end else if (mid_take) begin
          if (mi_r == 2'd2) begin
            state_nxt = C_PUSH;
            pc_nxt    = 2'd0;
          end else begin
            mi_nxt    = mi_r + 2'd1;
            state_nxt = C_MID;
          end
        end
      end
      C_PUSH: begin
        sp_nxt = sp_r + 1'b1;
        pc_nxt = pc_r + 2'd1;
        if (pc_r == 2'd2) begin
          state_nxt = C_NODE;
        end
      end
      C_EMIT: begin
        if (out_ch.ready) begin
          if (sp_r == '0) begin
            state_nxt = C_IDLE;
          end else begin
            sp_nxt    = sp_r - 1'b1;
            state_nxt = C_NODE;
          end
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      sp_r    <= '0;
      mi_r    <= 2'd0;
      pc_r    <= 2'd0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      mi_r    <= mi_nxt;
      pc_r    <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == C_PUSH) begin
      stack_r[sp_r[IDX_W-1:0]] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_take) begin
      mid_r[mi_r] <= mid_val;
    end
    if (state_r == C_IDLE && in_ch.valid) begin
      cur_r <= in_tri;
      lvl_r <= depth;
    end else if (state_r == C_PUSH && pc_r == 2'd2) begin
      cur_r <= '{a: cur_r.a, b: mid_r[0], c: mid_r[2]};
      lvl_r <= lvl_r - 1'b1;
    end else if (state_r == C_EMIT && out_ch.ready && sp_r != '0) begin
      cur_r <= stack_r[pop_idx].t;
      lvl_r <= stack_r[pop_idx].lvl;
    end
  end

  assign in_ch.ready          = state_r == C_IDLE;
  assign out_ch.valid         = state_r == C_EMIT;
  assign out_ch.last_triangle = sp_r == '0;
  assign out_ch.out_a_x       = cur_r.a.x;
  assign out_ch.out_a_y       = cur_r.a.y;
  assign out_ch.out_a_z       = cur_r.a.z;
  assign out_ch.out_b_x       = cur_r.b.x;
  assign out_ch.out_b_y       = cur_r.b.y;
  assign out_ch.out_b_z       = cur_r.b.z;
  assign out_ch.out_c_x       = cur_r.c.x;
  assign out_ch.out_c_y       = cur_r.c.y;
  assign out_ch.out_c_z       = cur_r.c.z;
endmodule
`default_nettype wire

// ===== rtl/midpoint_triangle_subdivider.sv =====
// Midpoint triangle subdivider.
// in_ch takes one triangle (three Q2.14 vertices) per transaction; out_ch
// returns 4^depth triangles depth-first, last_triangle marking the final one.
// cfg_ch writes subdivision_depth (index 0) and normalize_enable (index 1);
// it is always ready; the user must see that it is written only while the
// block is idle, which the block does not enforce. One triangle is worked
// at a time: in_ch.ready is high only when idle. Depth 0: the input passes
// the node state, then is emitted. Each inner node forms its three midpoints
// in turn, then pushes three child frames; each emitted triangle waits on
// out_ch.ready. With normalization on, each midpoint goes to the shared
// normalize unit: squares on one multiplier, the square root at two bits per
// cycle and, per component, the restoring divide at one bit per cycle.
// A stall on out_ch holds the triangle and all work until it is taken.
// Reset clears both configuration registers and returns the block to idle.
`default_nettype none
`include "midpoint_triangle_subdivider_macros.svh"
module midpoint_triangle_subdivider import mts_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  mts_in_if.sink    in_ch,
  mts_out_if.source out_ch,
  mts_cfg_if.sink   cfg_ch
);
  logic [LVL_W-1:0] depth_r;
  logic             norm_r;
  logic [LVL_W-1:0] depth_eff;
  norm_req_t        req;
  norm_rsp_t        rsp;

  assign cfg_ch.ready = 1'b1;
  assign depth_eff    = (depth_r > LVL_W'(MAX_DEPTH)) ? LVL_W'(MAX_DEPTH) : depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      norm_r  <= 1'b0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_DEPTH) begin
        depth_r <= cfg_ch.data[LVL_W-1:0];
      end else if (cfg_ch.index == REG_NORM) begin
        norm_r <= cfg_ch.data[0];
      end
    end
  end

  mts_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .depth   (depth_eff),
    .norm_en (norm_r),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .req     (req),
    .rsp     (rsp)
  );

  mts_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  `MTS_ASSERT_SAME(a_busy_excl, out_ch.valid, !in_ch.ready, "input ready with result pending")
  `MTS_ASSERT_NEXT(a_take_busy, in_ch.valid && in_ch.ready, !in_ch.ready, "ready after take")
  `MTS_ASSERT_NEXT(a_last_idle, out_ch.valid && out_ch.ready && out_ch.last_triangle, in_ch.ready, "not idle after last")
endmodule
`default_nettype wire

// ===== tb/tb_midpoint_triangle_subdivider.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_midpoint_triangle_subdivider;
  import mts_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 50;
  localparam int HOLD_CYCLES    = 400;

  typedef struct {
    tri_t t;
    logic last;
  } tri_result_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] depth_wr;
    logic [CFG_DATA_W-1:0] norm_wr;
    tri_t                  t;
    bit                    typed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mts_in_if  in_if();
  mts_out_if out_if();
  mts_cfg_if cfg_if();

  midpoint_triangle_subdivider u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always #1 clk = ~clk;

  tri_result_t tri_expected_q[$];
  int          mismatches = 0;
  int          stall_cycles = 0;
  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  int          hold_left = 0;
  logic [1:0]  cur_depth = '0;
  logic        cur_norm = 1'b0;
  stim_row_t   rows[$];

  initial begin
    in_if.valid  = 1'b0;
    in_if.in_a_x = '0; in_if.in_a_y = '0; in_if.in_a_z = '0;
    in_if.in_b_x = '0; in_if.in_b_y = '0; in_if.in_b_z = '0;
    in_if.in_c_x = '0; in_if.in_c_y = '0; in_if.in_c_z = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic vtx_t project_unit(vtx_t v);
    longint          comp[3];
    longint unsigned mag[3];
    longint unsigned sum, len, q;
    vtx_t            r;
    comp[0] = v.x; comp[1] = v.y; comp[2] = v.z;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (comp[i] < 0) ? longint'(-comp[i]) : longint'(comp[i]);
      sum += mag[i] * mag[i];
    end
    len = int_sqrt(sum);
    if (len == 0) return v;
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * (64'd1 << FRAC_W) + len / 2) / len;
      comp[i] = (comp[i] < 0) ? -longint'(q) : longint'(q);
    end
    r.x = coord_t'(comp[0]);
    r.y = coord_t'(comp[1]);
    r.z = coord_t'(comp[2]);
    return r;
  endfunction

  function automatic coord_t avg_floor(coord_t p, coord_t q);
    int s;
    s = int'(p) + int'(q);
    return coord_t'(s >>> 1);
  endfunction

  function automatic vtx_t edge_mid(vtx_t p, vtx_t q);
    vtx_t m;
    m.x = avg_floor(p.x, q.x);
    m.y = avg_floor(p.y, q.y);
    m.z = avg_floor(p.z, q.z);
    if (cur_norm) m = project_unit(m);
    return m;
  endfunction

  function automatic tri_t make_tri(vtx_t a, vtx_t b, vtx_t c);
    tri_t t;
    t.a = a; t.b = b; t.c = c;
    return t;
  endfunction

  function automatic vtx_t make_vtx(coord_t x, coord_t y, coord_t z);
    vtx_t v;
    v.x = x; v.y = y; v.z = z;
    return v;
  endfunction

  function automatic void split_tri(vtx_t v0, vtx_t v1, vtx_t v2, int level);
    vtx_t        m01, m12, m20;
    tri_result_t r;
    if (level == 0) begin
      r.t    = make_tri(v0, v1, v2);
      r.last = 1'b0;
      tri_expected_q.insert(tri_expected_q.size(), r);
      return;
    end
    m01 = edge_mid(v0, v1);
    m12 = edge_mid(v1, v2);
    m20 = edge_mid(v2, v0);
    split_tri(v0, m01, m20, level - 1);
    split_tri(m01, v1, m12, level - 1);
    split_tri(m20, m12, v2, level - 1);
    split_tri(m01, m12, m20, level - 1);
  endfunction

  function automatic void predict_tris(tri_t t);
    int depth;
    depth = (int'(cur_depth) > MAX_DEPTH) ? MAX_DEPTH : int'(cur_depth);
    split_tri(t.a, t.b, t.c, depth);
    tri_expected_q[tri_expected_q.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d triangles outstanding", tri_expected_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    tri_t        got;
    tri_result_t want;
    string       names[9];
    names = '{"a_x", "a_y", "a_z", "b_x", "b_y", "b_z", "c_x", "c_y", "c_z"};
    if (rst_n && out_if.valid && out_if.ready) begin
      got = make_tri(make_vtx(out_if.out_a_x, out_if.out_a_y, out_if.out_a_z),
                     make_vtx(out_if.out_b_x, out_if.out_b_y, out_if.out_b_z),
                     make_vtx(out_if.out_c_x, out_if.out_c_y, out_if.out_c_z));
      if (tri_expected_q.size() == 0) begin
        report_mismatch("unexpected triangle, last_triangle", out_if.last_triangle, -1);
      end else begin
        want = tri_expected_q.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (got[(8 - k) * COORD_W +: COORD_W] !== want.t[(8 - k) * COORD_W +: COORD_W])
            report_mismatch(names[k], coord_t'(got[(8 - k) * COORD_W +: COORD_W]),
                            coord_t'(want.t[(8 - k) * COORD_W +: COORD_W]));
        end
        if (out_if.last_triangle !== want.last)
          report_mismatch("last_triangle", out_if.last_triangle, want.last);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == REG_DEPTH) cur_depth = value[1:0];
    else if (idx == REG_NORM) cur_norm = value[0];
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain;
    while (tri_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_tri(tri_t t);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.in_a_x <= t.a.x; in_if.in_a_y <= t.a.y; in_if.in_a_z <= t.a.z;
    in_if.in_b_x <= t.b.x; in_if.in_b_y <= t.b.y; in_if.in_b_z <= t.b.z;
    in_if.in_c_x <= t.c.x; in_if.in_c_y <= t.c.y; in_if.in_c_z <= t.c.z;
    do @(posedge clk); while (!in_if.ready);
    predict_tris(t);
    @(negedge clk);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom_range(32768) - 16384);
      1: begin
        case ($urandom_range(3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic vtx_t rand_vtx();
    return make_vtx(rand_coord(), rand_coord(), rand_coord());
  endfunction

  task automatic add_row(logic [7:0] d, logic [7:0] n, tri_t t, bit typed);
    stim_row_t r;
    r.depth_wr = d; r.norm_wr = n; r.t = t; r.typed = typed;
    rows.insert(rows.size(), r);
  endtask

  initial begin
    vtx_t        vmax, vmin, vzero, vmix, vpat;
    tri_t        t;
    tri_result_t r;
    logic [7:0]  last_d, last_n;
    int          sent;
    int          phase_depth[7];
    int          phase_norm[7];
    int          phase_count[7];

    vmax  = make_vtx(16'sh7fff, 16'sh7fff, 16'sh7fff);
    vmin  = make_vtx(16'sh8000, 16'sh8000, 16'sh8000);
    vzero = make_vtx(16'sh0000, 16'sh0000, 16'sh0000);
    vmix  = make_vtx(16'sh7fff, 16'sh8000, 16'sh0000);
    vpat  = make_vtx(16'sh5555, 16'shaaaa, 16'sh4000);

    add_row(8'd0, 8'd0, make_tri(vzero, vzero, vzero), 1'b1);
    add_row(8'd0, 8'd0, make_tri(vmax, vmax, vmax), 1'b1);
    add_row(8'd0, 8'd0, make_tri(vmin, vmin, vmin), 1'b1);
    add_row(8'd0, 8'd0, make_tri(vmix, vpat, vmax), 1'b1);
    add_row(8'd0, 8'd0, make_tri(vpat, vmin, vmix), 1'b1);
    add_row(8'd1, 8'd0, make_tri(vmax, vmax, vmin), 1'b0);
    add_row(8'd1, 8'd0, make_tri(vmin, vmin, vmix), 1'b0);
    add_row(8'd1, 8'd0, make_tri(vpat, vmix, vzero), 1'b0);
    add_row(8'd1, 8'd1, make_tri(vzero, vzero, vzero), 1'b0);
    add_row(8'd1, 8'd1, make_tri(vmax, vmin, vpat), 1'b0);
    add_row(8'd1, 8'd1, make_tri(make_vtx(16'sh4000, 16'sh0000, 16'sh0000),
                                 make_vtx(16'sh0000, 16'sh4000, 16'sh0000),
                                 make_vtx(16'sh0000, 16'sh0000, 16'sh4000)), 1'b0);
    add_row(8'd2, 8'd1, make_tri(vmix, vmax, vmin), 1'b0);
    add_row(8'hff, 8'hfe, make_tri(vmax, vmin, vpat), 1'b0);
    add_row(8'hff, 8'hff, make_tri(make_vtx(16'sh4000, 16'sh0000, 16'sh0000),
                                   make_vtx(16'sh0000, 16'sh4000, 16'sh0000),
                                   make_vtx(16'shc000, 16'sh0000, 16'sh0000)), 1'b0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_reg(CFG_IDX_W'(7), 8'h03);
    last_d = 8'd0;
    last_n = 8'd0;
    foreach (rows[i]) begin
      if (rows[i].depth_wr != last_d || rows[i].norm_wr != last_n) begin
        in_if.valid <= 1'b0;
        drain();
        write_reg(REG_DEPTH, rows[i].depth_wr);
        write_reg(REG_NORM, rows[i].norm_wr);
        last_d = rows[i].depth_wr;
        last_n = rows[i].norm_wr;
      end
      if (rows[i].typed) begin
        in_if.valid  <= 1'b1;
        in_if.in_a_x <= rows[i].t.a.x; in_if.in_a_y <= rows[i].t.a.y;
        in_if.in_a_z <= rows[i].t.a.z; in_if.in_b_x <= rows[i].t.b.x;
        in_if.in_b_y <= rows[i].t.b.y; in_if.in_b_z <= rows[i].t.b.z;
        in_if.in_c_x <= rows[i].t.c.x; in_if.in_c_y <= rows[i].t.c.y;
        in_if.in_c_z <= rows[i].t.c.z;
        do @(posedge clk); while (!in_if.ready);
        r.t    = rows[i].t;
        r.last = 1'b1;
        tri_expected_q.insert(tri_expected_q.size(), r);
        @(negedge clk);
      end else begin
        send_tri(rows[i].t);
      end
    end
    in_if.valid <= 1'b0;

    phase_depth = '{1, 2, 0, 1, 2, 3, 3};
    phase_norm  = '{0, 0, 0, 1, 1, 0, 1};
    phase_count = '{150, 100, 90, 80, 40, 30, 8};
    sent = 0;
    for (int p = 0; p < 7; p++) begin
      drain();
      write_reg(REG_DEPTH, CFG_DATA_W'(phase_depth[p]));
      write_reg(REG_NORM, CFG_DATA_W'(phase_norm[p] | ($urandom_range(1) << 3)));
      for (int n = 0; n < phase_count[p]; n++) begin
        if (sent < 170) begin
          in_idle_pct = 33; out_idle_pct = 70;
        end else if (sent < 340) begin
          in_idle_pct = 70; out_idle_pct = 33;
        end else begin
          in_idle_pct = 0; out_idle_pct = 0;
        end
        if (sent == 60) hold_left = HOLD_CYCLES;
        if (sent == 120) begin
          in_if.valid <= 1'b0;
          drain();
        end
        if ($urandom_range(9) == 0) begin
          t = make_tri(vzero, rand_vtx(), vzero);
          t.c = make_vtx(-t.b.x, -t.b.y, -t.b.z);
        end else begin
          t = make_tri(rand_vtx(), rand_vtx(), rand_vtx());
        end
        send_tri(t);
        sent++;
      end
      in_if.valid <= 1'b0;
    end

    while (tri_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
